/* rtl/core/utfenc_pkg.sv */
// utfenc_pkg: shared constants, types and encode helpers for the utf-8 encoder
// no dependencies; imported by every utfenc module
`default_nettype none

package utfenc_pkg;

	localparam int unsigned CP_W      = 32;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned MAX_BYTES = 6;
	localparam int unsigned LEN_W     = 3;

	// sequence length codes
	localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
	localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
	localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
	localparam logic [LEN_W-1:0] LEN_4 = 3'd4;
	localparam logic [LEN_W-1:0] LEN_5 = 3'd5;
	localparam logic [LEN_W-1:0] LEN_6 = 3'd6;

	// length thresholds
	localparam logic [CP_W-1:0] LIM_2 = 32'h0000_0080;
	localparam logic [CP_W-1:0] LIM_3 = 32'h0000_0800;
	localparam logic [CP_W-1:0] LIM_4 = 32'h0001_0000;
	localparam logic [CP_W-1:0] LIM_5 = 32'h0020_0000;
	localparam logic [CP_W-1:0] LIM_6 = 32'h0400_0000;

	// lead and continuation prefixes
	localparam logic [BYTE_W-1:0] LEAD_2 = 8'hc0;
	localparam logic [BYTE_W-1:0] LEAD_3 = 8'he0;
	localparam logic [BYTE_W-1:0] LEAD_4 = 8'hf0;
	localparam logic [BYTE_W-1:0] LEAD_5 = 8'hf8;
	localparam logic [BYTE_W-1:0] LEAD_6 = 8'hfc;
	localparam logic [1:0]        CONT_TAG = 2'b10;

	typedef logic [MAX_BYTES-1:0][BYTE_W-1:0] byte_seq_t;

	// one encoded item: bytes in send order, lead byte in slot 0
	typedef struct packed {
		logic [LEN_W-1:0] len;
		byte_seq_t        seq;
	} enc_item_t;

	// number of bytes a code point needs
	function automatic logic [LEN_W-1:0] enc_len(input logic [CP_W-1:0] cp);
		logic [LEN_W-1:0] len;
		if (cp < LIM_2) begin
			len = LEN_1;
		end else if (cp < LIM_3) begin
			len = LEN_2;
		end else if (cp < LIM_4) begin
			len = LEN_3;
		end else if (cp < LIM_5) begin
			len = LEN_4;
		end else if (cp < LIM_6) begin
			len = LEN_5;
		end else begin
			len = LEN_6;
		end
		return len;
	endfunction

	// bytes of the sequence in send order
	function automatic byte_seq_t enc_seq(input logic [CP_W-1:0] cp,
	                                      input logic [LEN_W-1:0] len);
		byte_seq_t        seq;
		logic [LEN_W-1:0] pos;
		seq = '0;
		// continuation bytes: slot i carries six-bit group len-1-i
		for (int i = 1; i < MAX_BYTES; i++) begin
			pos = len - LEN_1 - LEN_W'(i);
			unique case (pos)
				3'd0:    seq[i] = {CONT_TAG, cp[5:0]};
				3'd1:    seq[i] = {CONT_TAG, cp[11:6]};
				3'd2:    seq[i] = {CONT_TAG, cp[17:12]};
				3'd3:    seq[i] = {CONT_TAG, cp[23:18]};
				3'd4:    seq[i] = {CONT_TAG, cp[29:24]};
				default: seq[i] = '0;
			endcase
		end
		// lead byte: prefix plus the bits left above the groups
		unique case (len)
			LEN_2:   seq[0] = LEAD_2 | {3'b000, cp[10:6]};
			LEN_3:   seq[0] = LEAD_3 | {4'b0000, cp[15:12]};
			LEN_4:   seq[0] = LEAD_4 | {5'b00000, cp[20:18]};
			LEN_5:   seq[0] = LEAD_5 | {6'b000000, cp[25:24]};
			LEN_6:   seq[0] = LEAD_6 | {6'b000000, cp[31:30]};
			default: seq[0] = {1'b0, cp[6:0]};
		endcase
		return seq;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/utfenc_front.sv */
// utfenc_front: input register stage and length classification stage
// depends on utfenc_pkg
`default_nettype none

module utfenc_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output      logic                       busy,
	input  wire logic [utfenc_pkg::CP_W-1:0] code_point,
	output      logic                       valid_s2,
	output      logic [utfenc_pkg::CP_W-1:0] cp_s2,
	output      logic [utfenc_pkg::LEN_W-1:0] len_s2,
	input  wire logic                       adv_s2
);
	import utfenc_pkg::*;

	logic            valid_s1;
	logic [CP_W-1:0] cp_s1;
	logic            adv_s1;
	logic            take;

	// stage moves when empty or when the next stage takes it
	assign adv_s1 = !valid_s1 || !valid_s2 || adv_s2;
	assign busy   = !adv_s1;
	assign take   = start && !busy;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cp_s1 <= code_point;
		end
	end

	// length stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv_s1) begin
			cp_s2  <= cp_s1;
			len_s2 <= enc_len(cp_s1);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/utfenc_pack.sv */
// utfenc_pack: builds the byte sequence of one code point into a register stage
// depends on utfenc_pkg
`default_nettype none

module utfenc_pack (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         valid_s2,
	input  wire logic [utfenc_pkg::CP_W-1:0]  cp_s2,
	input  wire logic [utfenc_pkg::LEN_W-1:0] len_s2,
	output      logic                         adv_s2,
	output      logic                         valid_s3,
	output      utfenc_pkg::enc_item_t        item_s3,
	input  wire logic                         ser_ready
);
	import utfenc_pkg::*;

	logic adv_s3;

	// handshake back up the pipe
	assign adv_s3 = !valid_s3 || ser_ready;
	assign adv_s2 = adv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	// byte assembly
	always_ff @(posedge clk) begin
		if (valid_s2 && adv_s3) begin
			item_s3.len <= len_s2;
			item_s3.seq <= enc_seq(cp_s2, len_s2);
		end
	end

endmodule

`default_nettype wire

/* rtl/core/utfenc_ser.sv */
// utfenc_ser: shifts out the bytes of one sequence, one beat per cycle
// depends on utfenc_pkg
`default_nettype none

module utfenc_ser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          valid_s3,
	input  wire utfenc_pkg::enc_item_t         item_s3,
	output      logic                          ser_ready,
	output      logic                          out_valid,
	output      logic [utfenc_pkg::BYTE_W-1:0] out_byte,
	output      logic                          last_byte
);
	import utfenc_pkg::*;

	byte_seq_t        hold_q;
	logic [LEN_W-1:0] cnt_q;
	logic             emit;
	logic             load;

	// a new sequence loads as the previous one sends its last byte
	assign emit      = (cnt_q != '0);
	assign ser_ready = (cnt_q == '0) || (cnt_q == LEN_1);
	assign load      = valid_s3 && ser_ready;

	// remaining byte count and output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			out_valid <= emit;
			if (load) begin
				cnt_q <= item_s3.len;
			end else if (emit) begin
				cnt_q <= cnt_q - LEN_1;
			end
		end
	end

	// byte shift register and output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte  <= hold_q[0];
			last_byte <= (cnt_q == LEN_1);
		end
		if (load) begin
			hold_q <= item_s3.seq;
		end else if (emit) begin
			hold_q <= {{BYTE_W{1'b0}}, hold_q[MAX_BYTES-1:1]};
		end
	end

endmodule

`default_nettype wire

/* rtl/core/utf8_codepoint_encoder_top.sv */
// utf8_codepoint_encoder_top: utf-8 encoder, original six-byte scheme
// depends on utfenc_pkg, utfenc_front, utfenc_pack, utfenc_ser
//
//   channel   handshake          payload
//   input     start / busy       code_point[31:0]
//   output    out_valid strobe   out_byte[7:0], last_byte
//
// a code point passes an input register, a length stage and a byte assembly
// stage, then a serializer that sends one byte beat per cycle.
// the lead byte then goes through the serializer's hold register and its output register.
// the serializer loads the next item as the current one sends its last byte, so
// sustained rate is one byte per cycle, and one code point per cycle for ascii.
// busy rises when the serializer backs up the pipe; output beats cannot stall.
// arst_n clears all valid bits and the byte count.
`default_nettype none

module utf8_codepoint_encoder_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output      logic                          busy,
	input  wire logic [utfenc_pkg::CP_W-1:0]   code_point,
	output      logic                          out_valid,
	output      logic [utfenc_pkg::BYTE_W-1:0] out_byte,
	output      logic                          last_byte
);
	import utfenc_pkg::*;

	logic             valid_s2;
	logic [CP_W-1:0]  cp_s2;
	logic [LEN_W-1:0] len_s2;
	logic             adv_s2;
	logic             valid_s3;
	enc_item_t        item_s3;
	logic             ser_ready;

	utfenc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.code_point (code_point),
		.valid_s2   (valid_s2),
		.cp_s2      (cp_s2),
		.len_s2     (len_s2),
		.adv_s2     (adv_s2)
	);

	utfenc_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.cp_s2     (cp_s2),
		.len_s2    (len_s2),
		.adv_s2    (adv_s2),
		.valid_s3  (valid_s3),
		.item_s3   (item_s3),
		.ser_ready (ser_ready)
	);

	utfenc_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s3  (valid_s3),
		.item_s3   (item_s3),
		.ser_ready (ser_ready),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule

`default_nettype wire
